FILE: src/fjs_pkg.sv
// ----------------------------------------------------------------------------
// Job scheduler package
// Codes, register indexes, state type and result record shared by the
// scheduler design.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fjs_pkg;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_DROPPED  = 3'd1;
    localparam logic [2:0] ST_IDLE     = 3'd2;
    localparam logic [2:0] ST_RAN      = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_RR   = 2'd1;
    localparam logic [1:0] POL_MLFQ = 2'd2;

    localparam logic [1:0] LVL_TOP = 2'd0;
    localparam logic [1:0] LVL_MID = 2'd1;
    localparam logic [1:0] LVL_BOT = 2'd2;

    localparam logic [1:0] LEVELS_THREE = 2'd3;

    localparam logic MODE_ARRIVAL = 1'b0;

    localparam logic [2:0] REG_POLICY   = 3'd0;
    localparam logic [2:0] REG_TOP_Q    = 3'd1;
    localparam logic [2:0] REG_MID_Q    = 3'd2;
    localparam logic [2:0] REG_BOT_Q    = 3'd3;
    localparam logic [2:0] REG_LEVELS   = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  running_id;
        logic [15:0] work_left;
        logic [31:0] finish_time;
    } result_t;

endpackage

`default_nettype wire

FILE: src/fifo_rr_feedback_job_scheduler_top.sv
// ----------------------------------------------------------------------------
// Multilevel feedback job scheduler
// Single-server scheduler with FIFO, round robin and feedback policies whose
// ready queues live in one shared synchronous queue memory.
// ----------------------------------------------------------------------------
// Every input word yields exactly one result word. An arrival writes the job
// to the tail of the top queue in the cycle it is accepted, if that queue
// has room. A tick that serves a job moves to the exec state: the accept
// cycle advances time and, when no job is running, updates the queue
// pointers and reads the head entry from the queue memory; the exec state
// applies the work unit and writes a preempted job back to a queue.
// Results pass through an output register plus one holding register, so one
// new word is taken while a result waits; beyond that the block waits for
// m_tready. The queue contents need no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module fifo_rr_feedback_job_scheduler_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [2:0]  cfg_addr,
    input  wire  [7:0]  cfg_wdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // job_id[7:0], work_units[23:8]
    input  wire         s_tuser,   // mode
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,   // running_id[7:0], work_left[23:8], finish_time[55:24]
    output logic [2:0]  m_tuser    // status
);

    localparam int IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W     = IDX_W + 1;
    localparam int MEM_DEPTH = 3 * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    fjs_pkg::state_t  state_reg, state_next;
    fjs_pkg::result_t m_res_reg, m_res_next;
    fjs_pkg::result_t pend_reg, pend_next;
    fjs_pkg::result_t res;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [1:0]        policy_reg;
    logic [7:0]        top_q_reg, mid_q_reg, bot_q_reg;
    logic [1:0]        levels_reg;
    logic [31:0]       now_reg, now_next;
    logic              busy_reg, busy_next;
    logic [23:0]       cur_job_reg, cur_job_next;
    logic [7:0]        slice_reg, slice_next;
    logic [1:0]        src_reg, src_next;
    logic              use_mem_reg, use_mem_next;
    logic [IDX_W-1:0]  head_reg [0:2];
    logic [IDX_W-1:0]  head_next [0:2];
    logic [CNT_W-1:0]  count_reg [0:2];
    logic [CNT_W-1:0]  count_next [0:2];

    logic [23:0]       mem [MEM_DEPTH];
    logic [23:0]       rdata_reg;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [23:0]       wr_data;

    logic              out_free, produce, fb, three, have, want_push;
    logic [1:0]        plvl;
    logic [7:0]        pq, sc;
    logic [23:0]       job;
    logic [15:0]       rem;
    logic              done;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [1:0] lvl,
                                                   input logic [IDX_W-1:0] idx);
        mem_addr = ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(idx);
    endfunction

    function automatic logic [IDX_W-1:0] tail_idx(input logic [IDX_W-1:0] head,
                                                  input logic [CNT_W-1:0] cnt);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(cnt);
        if (sum >= SUM_W'(QUEUE_DEPTH)) begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        tail_idx = sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] head_inc(input logic [IDX_W-1:0] head);
        head_inc = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + IDX_W'(1);
    endfunction

    assign out_free = !m_tvalid_reg || m_tready;
    assign fb       = (policy_reg == fjs_pkg::POL_MLFQ);
    assign three    = (levels_reg == fjs_pkg::LEVELS_THREE);
    assign s_tready = (state_reg == fjs_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {m_res_reg.finish_time, m_res_reg.work_left, m_res_reg.running_id};

    always_comb begin
        state_next    = state_reg;
        m_res_next    = m_res_reg;
        pend_next     = pend_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        now_next      = now_reg;
        busy_next     = busy_reg;
        cur_job_next  = cur_job_reg;
        slice_next    = slice_reg;
        src_next      = src_reg;
        use_mem_next  = use_mem_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        res           = '0;
        produce       = 1'b0;
        have          = 1'b0;
        want_push     = 1'b0;
        plvl          = fjs_pkg::LVL_TOP;
        pq            = '0;
        sc            = slice_reg;
        job           = use_mem_reg ? rdata_reg : cur_job_reg;
        rem           = (job[15:0] != 16'd0) ? job[15:0] - 16'd1 : 16'd0;
        done          = (rem == 16'd0);

        case (state_reg)
            fjs_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == fjs_pkg::MODE_ARRIVAL) begin
                        res.running_id = s_tdata[7:0];
                        if (count_reg[fjs_pkg::LVL_TOP] < CNT_W'(QUEUE_DEPTH)) begin
                            wr_en   = 1'b1;
                            wr_addr = mem_addr(fjs_pkg::LVL_TOP,
                                               tail_idx(head_reg[fjs_pkg::LVL_TOP],
                                                        count_reg[fjs_pkg::LVL_TOP]));
                            wr_data = {s_tdata[7:0], s_tdata[23:8]};
                            count_next[fjs_pkg::LVL_TOP] =
                                count_reg[fjs_pkg::LVL_TOP] + CNT_W'(1);
                            res.status = fjs_pkg::ST_ACCEPTED;
                        end else begin
                            res.status = fjs_pkg::ST_DROPPED;
                        end
                        produce = 1'b1;
                    end else begin
                        now_next     = now_reg + 32'd1;
                        use_mem_next = 1'b0;
                        if (!busy_reg) begin
                            if (!fb) begin
                                if (count_reg[fjs_pkg::LVL_TOP] != '0) begin
                                    have = 1'b1;
                                end
                            end else if (count_reg[fjs_pkg::LVL_TOP] != '0) begin
                                have = 1'b1;
                                pq   = top_q_reg;
                            end else if (three && count_reg[fjs_pkg::LVL_MID] != '0) begin
                                have = 1'b1;
                                plvl = fjs_pkg::LVL_MID;
                                pq   = mid_q_reg;
                            end else if (count_reg[fjs_pkg::LVL_BOT] != '0) begin
                                have = 1'b1;
                                plvl = fjs_pkg::LVL_BOT;
                                pq   = bot_q_reg;
                            end
                        end
                        if (have) begin
                            rd_en            = 1'b1;
                            rd_addr          = mem_addr(plvl, head_reg[plvl]);
                            head_next[plvl]  = head_inc(head_reg[plvl]);
                            count_next[plvl] = count_reg[plvl] - CNT_W'(1);
                            src_next         = plvl;
                            slice_next       = pq;
                            busy_next        = 1'b1;
                            use_mem_next     = 1'b1;
                            state_next       = fjs_pkg::S_EXEC;
                        end else if (busy_reg) begin
                            state_next = fjs_pkg::S_EXEC;
                        end else begin
                            res.status = fjs_pkg::ST_IDLE;
                            produce    = 1'b1;
                        end
                    end
                end
            end
            fjs_pkg::S_EXEC: begin
                cur_job_next = {job[23:16], rem};
                if (done) begin
                    busy_next = 1'b0;
                end else if (policy_reg == fjs_pkg::POL_RR) begin
                    if (sc != 8'hFF) begin
                        sc = sc + 8'd1;
                    end
                    if (sc >= top_q_reg && count_reg[fjs_pkg::LVL_TOP] != '0) begin
                        want_push = 1'b1;
                    end
                end else if (fb) begin
                    if (sc != 8'd0) begin
                        sc = sc - 8'd1;
                    end
                    if (sc == 8'd0) begin
                        want_push = 1'b1;
                        plvl = (src_reg == fjs_pkg::LVL_TOP && three) ?
                               fjs_pkg::LVL_MID : fjs_pkg::LVL_BOT;
                    end
                end
                slice_next = sc;
                if (want_push && count_reg[plvl] < CNT_W'(QUEUE_DEPTH)) begin
                    wr_en            = 1'b1;
                    wr_addr          = mem_addr(plvl, tail_idx(head_reg[plvl], count_reg[plvl]));
                    wr_data          = {job[23:16], rem};
                    count_next[plvl] = count_reg[plvl] + CNT_W'(1);
                    busy_next        = 1'b0;
                end
                res.status      = done ? fjs_pkg::ST_DONE : fjs_pkg::ST_RAN;
                res.running_id  = job[23:16];
                res.work_left   = rem;
                res.finish_time = done ? now_reg + 32'd1 : 32'd0;
                produce         = 1'b1;
            end
            fjs_pkg::S_HOLD: begin
                if (out_free) begin
                    m_res_next    = pend_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = fjs_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = fjs_pkg::S_IDLE;
            end
        endcase

        if (produce) begin
            if (out_free) begin
                m_res_next    = res;
                m_tvalid_next = 1'b1;
                state_next    = fjs_pkg::S_IDLE;
            end else begin
                pend_next  = res;
                state_next = fjs_pkg::S_HOLD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fjs_pkg::S_IDLE;
            m_tvalid_reg <= 1'b0;
            policy_reg   <= fjs_pkg::POL_FIFO;
            top_q_reg    <= 8'd2;
            mid_q_reg    <= 8'd3;
            bot_q_reg    <= 8'd4;
            levels_reg   <= 2'd2;
            now_reg      <= '0;
            busy_reg     <= 1'b0;
            cur_job_reg  <= '0;
            slice_reg    <= '0;
            src_reg      <= fjs_pkg::LVL_TOP;
            use_mem_reg  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            now_reg      <= now_next;
            busy_reg     <= busy_next;
            cur_job_reg  <= cur_job_next;
            slice_reg    <= slice_next;
            src_reg      <= src_next;
            use_mem_reg  <= use_mem_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    fjs_pkg::REG_POLICY: policy_reg <= cfg_wdata[1:0];
                    fjs_pkg::REG_TOP_Q:  top_q_reg  <= cfg_wdata;
                    fjs_pkg::REG_MID_Q:  mid_q_reg  <= cfg_wdata;
                    fjs_pkg::REG_BOT_Q:  bot_q_reg  <= cfg_wdata;
                    fjs_pkg::REG_LEVELS: levels_reg <= cfg_wdata[1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
        pend_reg  <= pend_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    a_exec_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fjs_pkg::S_EXEC) |-> $past(s_tvalid && s_tready))
        else $error("service cycle without an accepted tick");

    a_exec_has_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fjs_pkg::S_EXEC) |-> busy_reg)
        else $error("service cycle with no running job");

    a_hold_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fjs_pkg::S_HOLD) |-> m_tvalid_reg)
        else $error("pending result while output register is empty");

    a_arrival_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == fjs_pkg::MODE_ARRIVAL &&
         count_reg[fjs_pkg::LVL_TOP] < CNT_W'(QUEUE_DEPTH))
        |=> count_reg[fjs_pkg::LVL_TOP] == $past(count_reg[fjs_pkg::LVL_TOP]) + CNT_W'(1))
        else $error("top queue count did not grow on an accepted arrival");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg[fjs_pkg::LVL_TOP] <= CNT_W'(QUEUE_DEPTH) &&
        count_reg[fjs_pkg::LVL_MID] <= CNT_W'(QUEUE_DEPTH) &&
        count_reg[fjs_pkg::LVL_BOT] <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire
